// File: design/i2cee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C EEPROM master package
// Shared types, command codes, segment codes and the sequence program tables.
// ----------------------------------------------------------------------------
package i2cee_pkg;

    // Command codes carried in the input beat.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_RESET = 2'd3
    } op_t;

    // Sequence segments; the fixed pin patterns come first.
    typedef enum logic [3:0] {
        SEG_END    = 4'd0,
        SEG_START  = 4'd1,
        SEG_RSTART = 4'd2,
        SEG_STOP   = 4'd3,
        SEG_EXTRA  = 4'd4,
        SEG_CTRLW  = 4'd5,
        SEG_ADDR   = 4'd6,
        SEG_DATA   = 4'd7,
        SEG_CTRLR  = 4'd8,
        SEG_ONES   = 4'd9,
        SEG_RECV   = 4'd10
    } seg_t;

    localparam logic [7:0]  CTRL_BASE = 8'hA0;
    localparam logic [7:0]  CTRL_MASK = 8'hFE;
    localparam logic [7:0]  CTRL_RD   = 8'h01;
    localparam logic [11:0] ONES_PAT  = 12'hFF8;
    localparam logic [1:0]  PINS_IDLE = 2'b11;
    localparam int          PROG_LEN  = 8;

    // Latched command.
    typedef struct packed {
        op_t        op;
        logic [2:0] page;
        logic [7:0] addr;
        logic [7:0] data;
    } req_t;

    // One result beat.
    typedef struct packed {
        logic       cmd_rejected;
        logic       read_done;
        logic [7:0] read_byte;
        logic       busy_res;
        logic       sda_level;
        logic       scl_level;
    } res_t;

    // Segment at a program position (1..8) for a command.
    function automatic seg_t prog_seg(input op_t op, input logic [3:0] pos);
        seg_t s;
        s = SEG_END;
        unique case (op)
            OP_WRITE:
            begin
                unique case (pos)
                    4'd1:    s = SEG_START;
                    4'd2:    s = SEG_CTRLW;
                    4'd3:    s = SEG_ADDR;
                    4'd4:    s = SEG_DATA;
                    4'd5:    s = SEG_STOP;
                    default: s = SEG_END;
                endcase
            end
            OP_READ:
            begin
                unique case (pos)
                    4'd1:    s = SEG_START;
                    4'd2:    s = SEG_CTRLW;
                    4'd3:    s = SEG_ADDR;
                    4'd4:    s = SEG_RSTART;
                    4'd5:    s = SEG_CTRLR;
                    4'd6:    s = SEG_RECV;
                    4'd7:    s = SEG_STOP;
                    default: s = SEG_END;
                endcase
            end
            OP_RESET:
            begin
                unique case (pos)
                    4'd1:    s = SEG_START;
                    4'd2:    s = SEG_ONES;
                    4'd3:    s = SEG_EXTRA;
                    4'd4:    s = SEG_STOP;
                    default: s = SEG_END;
                endcase
            end
            default: s = SEG_END;
        endcase
        return s;
    endfunction

    // Number of phases in a fixed segment.
    function automatic logic [3:0] fixed_len(input seg_t seg);
        return (seg == SEG_START) ? 4'd2 : 4'd3;
    endfunction

    // Pin code {scl, sda} of a phase in a fixed segment.
    function automatic logic [1:0] fixed_pins(input seg_t seg, input logic [1:0] idx);
        logic [1:0] p;
        p = PINS_IDLE;
        unique case (seg)
            SEG_START:
            begin
                p = (idx == 2'd1) ? 2'b10 : 2'b11;
            end
            SEG_RSTART, SEG_EXTRA:
            begin
                unique case (idx)
                    2'd0:    p = 2'b01;
                    2'd1:    p = 2'b11;
                    2'd2:    p = 2'b10;
                    default: p = PINS_IDLE;
                endcase
            end
            SEG_STOP:
            begin
                unique case (idx)
                    2'd0:    p = 2'b00;
                    2'd1:    p = 2'b10;
                    default: p = PINS_IDLE;
                endcase
            end
            default: p = PINS_IDLE;
        endcase
        return p;
    endfunction

    // Number of clocked bits in a byte segment.
    function automatic logic [3:0] seg_bits(input seg_t seg);
        return (seg == SEG_RECV) ? 4'd8 : 4'd9;
    endfunction

    // SDA level for a bit of a byte segment; the ninth bit is the released ack.
    function automatic logic bit_sda(input seg_t seg, input logic [3:0] bidx,
                                     input logic [11:0] shift);
        logic [11:0] sh;
        logic        b;
        sh = 12'd0;
        b  = 1'b1;
        if (seg == SEG_ONES)
        begin
            sh = shift >> (4'd11 - bidx);
            b  = (bidx <= 4'd8) ? sh[0] : 1'b1;
        end
        else if (seg != SEG_RECV)
        begin
            sh = shift >> (4'd7 - bidx);
            b  = (bidx < 4'd8) ? sh[0] : 1'b1;
        end
        return b;
    endfunction

endpackage

// File: design/i2cee_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C EEPROM master pin sequencer
// Holds the sequence state and advances it by one tick for each accepted beat.
// ----------------------------------------------------------------------------
module i2cee_seq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [1:0]        opcode,
    input  logic [2:0]        device_page,
    input  logic [7:0]        mem_address,
    input  logic [7:0]        write_data,
    input  logic              sda_in,
    input  logic [15:0]       half_period,
    output i2cee_pkg::res_t   res
);
    import i2cee_pkg::*;

    logic [3:0]  step_reg,  step_next;
    logic [15:0] hold_reg,  hold_next;
    logic [3:0]  bidx_reg,  bidx_next;
    logic [11:0] shift_reg, shift_next;
    req_t        req_reg,   req_next;
    logic [1:0]  pin_reg,   pin_next;

    logic [15:0] hp;
    logic [16:0] hold_inc;
    seg_t        seg;
    seg_t        new_seg;
    logic [3:0]  bi_inc;
    logic [11:0] shift_adv;
    logic        do_enter;
    logic [3:0]  enter_pos;
    req_t        enter_req;
    logic [7:0]  ctrl;
    logic        ended;
    logic        rejected;

    // A zero hold time counts as one tick.
    assign hp  = (half_period == 16'd0) ? 16'd1 : half_period;
    assign seg = (step_reg == 4'd0 || step_reg > 4'(PROG_LEN)) ?
                 SEG_END : prog_seg(req_reg.op, step_reg);

    // Next state for one tick.
    always_comb
    begin
        step_next  = step_reg;
        hold_next  = hold_reg;
        bidx_next  = bidx_reg;
        shift_next = shift_reg;
        req_next   = req_reg;
        pin_next   = pin_reg;
        rejected   = 1'b0;
        do_enter   = 1'b0;
        enter_pos  = 4'd0;
        enter_req  = req_reg;
        hold_inc   = {1'b0, hold_reg} + 17'd1;
        bi_inc     = bidx_reg + 4'd1;
        shift_adv  = shift_reg;
        ended      = 1'b0;
        new_seg    = SEG_END;
        ctrl       = 8'd0;

        if (step_reg != 4'd0)
        begin
            rejected = (op_t'(opcode) != OP_TICK);
            if (hold_inc >= {1'b0, hp})
            begin
                // Phase held long enough: move to the next phase.
                hold_next = 16'd0;
                if (seg == SEG_END)
                begin
                    do_enter = 1'b1;
                end
                else if (seg <= SEG_EXTRA)
                begin
                    bidx_next = bi_inc;
                    if (bi_inc >= fixed_len(seg))
                    begin
                        do_enter  = 1'b1;
                        enter_pos = step_reg + 4'd1;
                    end
                    else
                    begin
                        pin_next = fixed_pins(seg, bi_inc[1:0]);
                    end
                end
                else if (!pin_reg[1])
                begin
                    // Low half of a bit: raise SCL.
                    pin_next = pin_reg | 2'b10;
                end
                else
                begin
                    // End of a bit: sample on a read, then present the next bit.
                    if (seg == SEG_RECV)
                    begin
                        shift_adv = {4'd0, shift_reg[6:0], sda_in};
                    end
                    shift_next = shift_adv;
                    bidx_next  = bi_inc;
                    if (bi_inc >= seg_bits(seg))
                    begin
                        do_enter  = 1'b1;
                        enter_pos = step_reg + 4'd1;
                    end
                    else
                    begin
                        pin_next = {1'b0, bit_sda(seg, bi_inc, shift_adv)};
                    end
                end
            end
            else
            begin
                hold_next = hold_inc[15:0];
            end
        end
        else if (op_t'(opcode) != OP_TICK)
        begin
            // Idle and a command arrives: latch it and enter the first segment.
            req_next.op   = op_t'(opcode);
            req_next.page = device_page;
            req_next.addr = mem_address;
            req_next.data = write_data;
            enter_req     = req_next;
            hold_next     = 16'd0;
            do_enter      = 1'b1;
            enter_pos     = 4'd1;
        end

        // Segment entry: load the shifter and the first pin phase, or return to idle at the end.
        if (do_enter)
        begin
            new_seg   = (enter_pos == 4'd0 || enter_pos > 4'(PROG_LEN)) ?
                        SEG_END : prog_seg(enter_req.op, enter_pos);
            ctrl      = (CTRL_BASE | {4'd0, enter_req.page, 1'b0}) & CTRL_MASK;
            step_next = enter_pos;
            bidx_next = 4'd0;
            if (new_seg == SEG_END)
            begin
                ended     = 1'b1;
                step_next = 4'd0;
                pin_next  = PINS_IDLE;
                hold_next = 16'd0;
            end
            else
            begin
                unique case (new_seg)
                    SEG_CTRLW: shift_next = {4'd0, ctrl};
                    SEG_CTRLR: shift_next = {4'd0, ctrl | CTRL_RD};
                    SEG_ADDR:  shift_next = {4'd0, enter_req.addr};
                    SEG_DATA:  shift_next = {4'd0, enter_req.data};
                    SEG_ONES:  shift_next = ONES_PAT;
                    SEG_RECV:  shift_next = 12'd0;
                    default:   shift_next = shift_next;
                endcase
                if (new_seg <= SEG_EXTRA)
                begin
                    pin_next = fixed_pins(new_seg, 2'd0);
                end
                else
                begin
                    pin_next = {1'b0, bit_sda(new_seg, 4'd0, shift_next)};
                end
            end
        end

        // Result beat, taken from the state after this tick.
        res.scl_level    = pin_next[1];
        res.sda_level    = pin_next[0];
        res.busy_res     = (step_next != 4'd0);
        res.read_done    = ended && (step_reg != 4'd0) && (req_reg.op == OP_READ);
        res.read_byte    = res.read_done ? shift_next[7:0] : 8'd0;
        res.cmd_rejected = rejected;
    end

    // Sequence state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 4'd0;
            hold_reg  <= 16'd0;
            bidx_reg  <= 4'd0;
            shift_reg <= 12'd0;
            req_reg   <= '0;
            pin_reg   <= PINS_IDLE;
        end
        else if (step_en)
        begin
            step_reg  <= step_next;
            hold_reg  <= hold_next;
            bidx_reg  <= bidx_next;
            shift_reg <= shift_next;
            req_reg   <= req_next;
            pin_reg   <= pin_next;
        end
    end

endmodule

// File: design/i2cee_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C EEPROM master result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module i2cee_obuf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  i2cee_pkg::res_t   res,
    output logic              free,
    input  logic              m_axis_tready,
    output logic              m_axis_tvalid,
    output logic [15:0]       m_axis_tdata
);
    import i2cee_pkg::*;

    logic        valid_reg;
    logic [15:0] data_reg;

    // Room for a new beat when empty or when the held beat leaves now.
    assign free          = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    // Payload, packed from the lowest bit up.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {3'd0, res};
        end
    end

endmodule

// File: design/i2c_eeprom_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C EEPROM master
// Byte write, random read and bus reset sequences for a serial EEPROM,
// stepped by one tick beat at a time.
// ----------------------------------------------------------------------------
// Each input beat is one tick and gives one result beat with the SCL and SDA
// levels after that tick. The block takes one beat per clock; its result is
// in the output register on the next clock. The only stall comes from the
// output register: s_axis_tready is low while a result is held and
// m_axis_tready is low. Commands are taken only while idle; a command during
// a sequence is dropped and flagged in cmd_rejected. half_period is written
// through cfg_we/cfg_wdata and should be changed only while idle.
module i2c_eeprom_master
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,      // half_period
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // device_page, mem_address, write_data, sda_in
    input  logic [1:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // scl_level, sda_level, busy_res, read_byte,
                                        // read_done, cmd_rejected
);
    import i2cee_pkg::*;

    logic [15:0] half_period_reg;
    logic        in_fire;
    logic        obuf_free;
    res_t        res;

    assign s_axis_tready = obuf_free;
    assign in_fire       = s_axis_tvalid && obuf_free;

    // Hold time register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            half_period_reg <= cfg_wdata;
        end
    end

    // Pin sequencer.
    i2cee_seq u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (in_fire),
        .opcode      (s_axis_tuser),
        .device_page (s_axis_tdata[2:0]),
        .mem_address (s_axis_tdata[10:3]),
        .write_data  (s_axis_tdata[18:11]),
        .sda_in      (s_axis_tdata[19]),
        .half_period (half_period_reg),
        .res         (res)
    );

    // Result register.
    i2cee_obuf u_obuf
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (in_fire),
        .res           (res),
        .free          (obuf_free),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: bench/tb_i2c_eeprom_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the I2C EEPROM master
// Drives tick beats with byte write, random read and bus reset commands.
// A cycle-true prediction of the pin sequencer checks every result beat.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the sequencer state and of half_period.
// Each accepted input beat advances that copy by one tick and queues the
// expected SCL/SDA levels, busy flag, read byte and reject flag. A checker
// compares each result beat, field by field, with the oldest expected one.
// Both stream sides insert random gaps, except during one steady stretch.
// half_period is written only when the sequencer is idle and the result
// queue is empty.
module tb_i2c_eeprom_master;

    import i2cee_pkg::*;

    localparam int RANDOM_BEATS = 400;
    localparam int MAX_PRINTS   = 30;
    localparam int IDLE_PCT     = 35;

    // SDA patterns for the slave side while a sequence runs.
    localparam int SDA_LOW    = 0;
    localparam int SDA_HIGH   = 1;
    localparam int SDA_RANDOM = 2;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;     // device_page, mem_address, write_data, sda_in
    logic [1:0]  s_axis_tuser;     // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;     // scl_level, sda_level, busy_res, read_byte,
                                   // read_done, cmd_rejected

    // Bench bookkeeping.
    res_t bus_state_q [$];
    int   error_count     = 0;
    int   beats_sent      = 0;
    int   results_checked = 0;
    int   reads_seen      = 0;
    int   rejects_seen    = 0;
    int   seq_started [4] = '{0, 0, 0, 0};
    bit   steady_flow     = 1'b0;

    // Predicted sequencer state.
    logic [15:0] half_cfg;
    logic [3:0]  seq_pos;
    logic [16:0] hold_ticks;
    logic [3:0]  phase_idx;
    logic [11:0] shift_pat;
    req_t        held_req;
    logic [1:0]  line_pins;        // {scl, sda}

    // Segment order of each command.
    seg_t write_prog [0:7] = '{SEG_START, SEG_CTRLW, SEG_ADDR, SEG_DATA,
                               SEG_STOP, SEG_END, SEG_END, SEG_END};
    seg_t read_prog  [0:7] = '{SEG_START, SEG_CTRLW, SEG_ADDR, SEG_RSTART,
                               SEG_CTRLR, SEG_RECV, SEG_STOP, SEG_END};
    seg_t reset_prog [0:7] = '{SEG_START, SEG_ONES, SEG_EXTRA, SEG_STOP,
                               SEG_END, SEG_END, SEG_END, SEG_END};

    i2c_eeprom_master u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("tb_i2c_eeprom_master: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequencer prediction
    // ------------------------------------------------------------------------

    // Segment at program position pos (1..8) of a command.
    function automatic seg_t segment_at(input op_t op, input logic [3:0] pos);
        if (pos == 4'd0 || pos > 4'd8)
            return SEG_END;
        case (op)
            OP_WRITE: return write_prog[pos - 4'd1];
            OP_READ:  return read_prog[pos - 4'd1];
            OP_RESET: return reset_prog[pos - 4'd1];
            default:  return SEG_END;
        endcase
    endfunction

    // Pin levels {scl, sda} of one phase of a fixed segment.
    function automatic logic [1:0] phase_pins(input seg_t seg, input logic [3:0] idx);
        case (seg)
            SEG_START:
                return (idx == 4'd0) ? 2'b11 : 2'b10;
            SEG_RSTART, SEG_EXTRA:
                return (idx == 4'd0) ? 2'b01 : (idx == 4'd1) ? 2'b11 : 2'b10;
            SEG_STOP:
                return (idx == 4'd0) ? 2'b00 : (idx == 4'd1) ? 2'b10 : 2'b11;
            default:
                return PINS_IDLE;
        endcase
    endfunction

    // SDA level of bit idx in a byte segment; past the data bits SDA is released.
    function automatic logic byte_level(input seg_t seg, input logic [3:0] idx);
        if (seg == SEG_RECV)
            return 1'b1;
        if (seg == SEG_ONES)
            return (idx <= 4'd8) ? shift_pat[4'd11 - idx] : 1'b1;
        return (idx < 4'd8) ? shift_pat[4'd7 - idx] : 1'b1;
    endfunction

    // Moves to program position pos; returns 1 when the sequence is over.
    function automatic bit enter_segment(input logic [3:0] pos);
        seg_t       seg;
        logic [7:0] ctrl;
        ctrl      = (CTRL_BASE | {4'd0, held_req.page, 1'b0}) & CTRL_MASK;
        seq_pos   = pos;
        seg       = segment_at(held_req.op, pos);
        phase_idx = 4'd0;
        if (seg == SEG_END)
        begin
            seq_pos    = 4'd0;
            line_pins  = PINS_IDLE;
            hold_ticks = '0;
            return 1'b1;
        end
        case (seg)
            SEG_CTRLW: shift_pat = {4'd0, ctrl};
            SEG_CTRLR: shift_pat = {4'd0, ctrl | CTRL_RD};
            SEG_ADDR:  shift_pat = {4'd0, held_req.addr};
            SEG_DATA:  shift_pat = {4'd0, held_req.data};
            SEG_ONES:  shift_pat = ONES_PAT;
            SEG_RECV:  shift_pat = 12'd0;
            default:   shift_pat = shift_pat;
        endcase
        if (seg <= SEG_EXTRA)
            line_pins = phase_pins(seg, 4'd0);
        else
            line_pins = {1'b0, byte_level(seg, 4'd0)};
        return 1'b0;
    endfunction

    // Steps to the next pin phase once the hold has run out.
    function automatic bit advance_phase(input logic sda);
        seg_t seg;
        seg = segment_at(held_req.op, seq_pos);
        if (seg == SEG_END)
            return enter_segment(4'd0);
        if (seg <= SEG_EXTRA)
        begin
            phase_idx++;
            if (phase_idx >= ((seg == SEG_START) ? 4'd2 : 4'd3))
                return enter_segment(seq_pos + 4'd1);
            line_pins = phase_pins(seg, phase_idx);
            return 1'b0;
        end
        // Low half of a clocked bit: raise SCL, keep SDA.
        if (!line_pins[1])
        begin
            line_pins[1] = 1'b1;
            return 1'b0;
        end
        // End of the high half: the slave's bit is taken here during a read.
        if (seg == SEG_RECV)
            shift_pat = {4'd0, shift_pat[6:0], sda};
        phase_idx++;
        if (phase_idx >= ((seg == SEG_RECV) ? 4'd8 : 4'd9))
            return enter_segment(seq_pos + 4'd1);
        line_pins = {1'b0, byte_level(seg, phase_idx)};
        return 1'b0;
    endfunction

    // One tick of the master: returns the expected result beat.
    function automatic res_t step_bus_sequencer(input op_t op, input logic [2:0] page,
                                                input logic [7:0] addr,
                                                input logic [7:0] data, input logic sda);
        res_t        r;
        op_t         run_op;
        logic [16:0] hp;
        r  = '0;
        hp = (half_cfg == 16'd0) ? 17'd1 : {1'b0, half_cfg};
        if (seq_pos != 4'd0)
        begin
            run_op = held_req.op;
            if (op != OP_TICK)
                r.cmd_rejected = 1'b1;
            hold_ticks++;
            if (hold_ticks >= hp)
            begin
                hold_ticks = '0;
                if (advance_phase(sda) && run_op == OP_READ)
                begin
                    r.read_done = 1'b1;
                    r.read_byte = shift_pat[7:0];
                end
            end
        end
        else if (op != OP_TICK)
        begin
            held_req.op   = op;
            held_req.page = page;
            held_req.addr = addr;
            held_req.data = data;
            hold_ticks    = '0;
            seq_started[op]++;
            void'(enter_segment(4'd1));
        end
        r.scl_level = line_pins[1];
        r.sda_level = line_pins[0];
        r.busy_res  = (seq_pos != 4'd0);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus and checking helpers
    // ------------------------------------------------------------------------

    // Prints one mismatch line (up to a cap) and counts it.
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch at result beat %0d: %s got 0x%0h expected 0x%0h",
                     results_checked, what, got, want);
    endtask

    // Sends one input beat and queues its predicted result on acceptance.
    task automatic send_beat(input op_t op, input logic [2:0] page, input logic [7:0] addr,
                             input logic [7:0] data, input logic sda);
        if (!steady_flow)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, sda, data, addr, page};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bus_state_q.push_back(step_bus_sequencer(op, page, addr, data, sda));
        beats_sent++;
        @(negedge clk);
    endtask

    // Ticks until the running sequence ends; nag_pct of the ticks carry a command.
    task automatic drain_sequence(input int sda_mode, input int nag_pct);
        logic sda;
        op_t  op;
        while (seq_pos != 4'd0)
        begin
            sda = (sda_mode == SDA_RANDOM) ? logic'($urandom_range(1)) : logic'(sda_mode);
            op  = ($urandom_range(99) < nag_pct) ? op_t'($urandom_range(1, 3)) : OP_TICK;
            send_beat(op, 3'($urandom_range(7)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), sda);
        end
    endtask

    // Issues one command from idle and runs it to its end.
    task automatic run_command(input op_t op, input logic [2:0] page, input logic [7:0] addr,
                               input logic [7:0] data, input int sda_mode, input int nag_pct);
        send_beat(op, page, addr, data, 1'($urandom_range(1)));
        drain_sequence(sda_mode, nag_pct);
    endtask

    // Writes half_period once the block is idle and all results are in.
    task automatic set_half_period(input logic [15:0] value);
        drain_sequence(SDA_RANDOM, 0);
        s_axis_tvalid <= 1'b0;
        while (bus_state_q.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        half_cfg   = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Plain ticks while idle, with the field extremes.
    task automatic test_idle_ticks();
        send_beat(OP_TICK, 3'd0, 8'h00, 8'h00, 1'b0);
        send_beat(OP_TICK, 3'd7, 8'hFF, 8'hFF, 1'b1);
        send_beat(OP_TICK, 3'd5, 8'hA5, 8'h5A, 1'b0);
    endtask

    task automatic test_byte_write();
        run_command(OP_WRITE, 3'd7, 8'hFF, 8'h00, SDA_RANDOM, 0);
        run_command(OP_WRITE, 3'd0, 8'h00, 8'hFF, SDA_RANDOM, 0);
    endtask

    // Random reads with the slave holding SDA low, high and toggling.
    task automatic test_random_read();
        run_command(OP_READ, 3'd5, 8'hA5, 8'h5A, SDA_RANDOM, 0);
        run_command(OP_READ, 3'd0, 8'h00, 8'hFF, SDA_HIGH, 0);
        run_command(OP_READ, 3'd7, 8'hFF, 8'h00, SDA_LOW, 0);
    endtask

    task automatic test_bus_reset();
        run_command(OP_RESET, 3'd2, 8'h3C, 8'hC3, SDA_RANDOM, 0);
    endtask

    // Every tick of a sequence carries a command, the final tick included.
    task automatic test_busy_commands();
        run_command(OP_WRITE, 3'd3, 8'h81, 8'h7E, SDA_RANDOM, 100);
        run_command(OP_READ, 3'd6, 8'h18, 8'hE7, SDA_RANDOM, 100);
        run_command(OP_RESET, 3'd1, 8'h42, 8'h24, SDA_RANDOM, 100);
    endtask

    // Zero behaves as one; longer holds stretch every phase.
    task automatic test_half_period();
        set_half_period(16'd0);
        run_command(OP_READ, 3'd4, 8'h96, 8'h69, SDA_RANDOM, 0);
        set_half_period(16'd3);
        run_command(OP_WRITE, 3'd1, 8'h0F, 8'hF0, SDA_RANDOM, 10);
        set_half_period(16'd2);
        run_command(OP_RESET, 3'd6, 8'hC0, 8'h03, SDA_RANDOM, 0);
        set_half_period(16'd1);
    endtask

    // Mostly complete sequences with random content, some loose beats.
    task automatic test_random_traffic();
        int   first;
        int   done;
        op_t  op;
        first = beats_sent;
        done  = 0;
        while (done < RANDOM_BEATS)
        begin
            steady_flow = (done >= 100 && done < 250);
            if ($urandom_range(99) < 8)
                set_half_period(($urandom_range(99) < 50) ? 16'd1 : 16'($urandom_range(0, 4)));
            if ($urandom_range(99) < 75)
            begin
                drain_sequence(SDA_RANDOM, 8);
                op = op_t'($urandom_range(1, 3));
                run_command(op, 3'($urandom_range(7)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), SDA_RANDOM, 8);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_beat(op_t'($urandom_range(3)), 3'($urandom_range(7)),
                              8'($urandom_range(255)), 8'($urandom_range(255)),
                              1'($urandom_range(1)));
            end
            done = beats_sent - first;
        end
        steady_flow = 1'b0;
    endtask

    // Largest hold: the first phase of a bus reset, left running at the end.
    task automatic test_long_hold();
        set_half_period(16'hFFFF);
        send_beat(OP_RESET, 3'd7, 8'hFF, 8'hFF, 1'b1);
        repeat (200)
            send_beat(($urandom_range(99) < 10) ? op_t'($urandom_range(1, 3)) : OP_TICK,
                      3'($urandom_range(7)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        res_t got;
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = res_t'(m_axis_tdata[12:0]);
            if (m_axis_tdata[15:13] != 3'd0)
                report_mismatch("padding bits", {13'd0, m_axis_tdata[15:13]}, 16'd0);
            if (bus_state_q.size() == 0)
            begin
                report_mismatch("result beat with nothing expected", m_axis_tdata, 16'd0);
            end
            else
            begin
                want = bus_state_q.pop_front();
                if (got.scl_level != want.scl_level)
                    report_mismatch("scl_level", 16'(got.scl_level), 16'(want.scl_level));
                if (got.sda_level != want.sda_level)
                    report_mismatch("sda_level", 16'(got.sda_level), 16'(want.sda_level));
                if (got.busy_res != want.busy_res)
                    report_mismatch("busy_res", 16'(got.busy_res), 16'(want.busy_res));
                if (got.read_byte != want.read_byte)
                    report_mismatch("read_byte", 16'(got.read_byte), 16'(want.read_byte));
                if (got.read_done != want.read_done)
                    report_mismatch("read_done", 16'(got.read_done), 16'(want.read_done));
                if (got.cmd_rejected != want.cmd_rejected)
                    report_mismatch("cmd_rejected", 16'(got.cmd_rejected),
                                    16'(want.cmd_rejected));
                if (want.read_done)
                    reads_seen++;
                if (want.cmd_rejected)
                    rejects_seen++;
            end
            results_checked++;
        end
    end

    // Result side: random stalls except during the steady stretch.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 16'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 24'd0;
        s_axis_tuser  = OP_TICK;

        // Prediction starts from the reset state.
        half_cfg   = 16'd1;
        seq_pos    = 4'd0;
        hold_ticks = '0;
        phase_idx  = 4'd0;
        shift_pat  = 12'd0;
        held_req   = '0;
        line_pins  = PINS_IDLE;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_ticks();
        test_byte_write();
        test_random_read();
        test_bus_reset();
        test_busy_commands();
        test_half_period();
        test_random_traffic();
        test_long_hold();

        // Let every queued result come out.
        s_axis_tvalid <= 1'b0;
        while (bus_state_q.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);

        $display("Sent %0d tick beats: %0d writes, %0d reads, %0d bus resets started.",
                 beats_sent, seq_started[OP_WRITE], seq_started[OP_READ],
                 seq_started[OP_RESET]);
        $display("Checked %0d result beats with %0d completed reads and %0d rejected commands.",
                 results_checked, reads_seen, rejects_seen);
        if (error_count == 0)
            $display("tb_i2c_eeprom_master: clean");
        else
            $display("tb_i2c_eeprom_master: errors");
        $finish;
    end

endmodule

// File: filelist.f
design/i2cee_pkg.sv
design/i2cee_seq.sv
design/i2cee_obuf.sv
design/i2c_eeprom_master.sv
bench/tb_i2c_eeprom_master.sv
